// ===== rtl/cpcp_pkg.sv =====
// Shared constants and types for the channel pair cross power block.
// No dependencies; every other file of the block imports this package.
package cpcp_pkg;

    localparam int MAX_CHANNELS = 8;
    localparam int CH_W         = $clog2(MAX_CHANNELS);
    localparam int NUM_W        = 4;
    localparam int SAMPLE_W     = 16;
    localparam int WORD_W       = 2 * SAMPLE_W;
    localparam int BIN_W        = 12;
    localparam int PROD_W       = 32;
    localparam int S_DATA_W     = 48;
    localparam int M_DATA_W     = 56;

    // Sequencer states
    typedef enum logic [1:0] {
        SEQ_IDLE = 2'b01,
        SEQ_EMIT = 2'b10
    } seq_state_t;

    // One product request travelling down the multiply pipeline
    typedef struct packed {
        logic [CH_W-1:0]  row;
        logic [CH_W-1:0]  col;
        logic             imag;
        logic             last;
        logic [BIN_W-1:0] bin;
    } prod_tag_t;

endpackage

// ===== rtl/cpcp_sample_ram.sv =====
// Sample memory: one write port, two registered read ports with a shared enable.
// Depends on cpcp_pkg for widths and depth.
module cpcp_sample_ram import cpcp_pkg::*; (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [CH_W-1:0]   wr_addr,
    input  logic [WORD_W-1:0] wr_data,
    input  logic              rd_en,
    input  logic [CH_W-1:0]   rd_addr_a,
    input  logic [CH_W-1:0]   rd_addr_b,
    output logic [WORD_W-1:0] rd_data_a,
    output logic [WORD_W-1:0] rd_data_b
);

    logic [WORD_W-1:0] mem [MAX_CHANNELS];
    logic [WORD_W-1:0] rd_a_reg;
    logic [WORD_W-1:0] rd_b_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Hold the read data while the pipeline stalls
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_a_reg <= mem[rd_addr_a];
            rd_b_reg <= mem[rd_addr_b];
        end
    end

    assign rd_data_a = rd_a_reg;
    assign rd_data_b = rd_b_reg;

endmodule

// ===== rtl/cpcp_pair_seq.sv =====
// Pair sequencer: walks row<=col pairs, real then imaginary, one request per cycle while adv is high.
// Depends on cpcp_pkg for the state enum and the request tag.
module cpcp_pair_seq import cpcp_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [CH_W-1:0]  n_last,
    input  logic [BIN_W-1:0] bin,
    input  logic             adv,
    output logic             busy,
    output logic             issue,
    output prod_tag_t        tag
);

    seq_state_t      state_reg, state_next;
    logic [CH_W-1:0] row_reg, row_next;
    logic [CH_W-1:0] col_reg, col_next;
    logic            imag_reg, imag_next;
    logic            final_step;

    assign busy  = (state_reg == SEQ_EMIT);
    assign issue = busy && adv;

    assign final_step = !imag_reg && (row_reg == n_last) && (col_reg == n_last);

    assign tag.row  = imag_reg ? col_reg : row_reg;
    assign tag.col  = imag_reg ? row_reg : col_reg;
    assign tag.imag = imag_reg;
    assign tag.last = final_step;
    assign tag.bin  = bin;

    always_comb begin
        state_next = state_reg;
        row_next   = row_reg;
        col_next   = col_reg;
        imag_next  = imag_reg;
        case (state_reg)
            SEQ_IDLE: begin
                if (start) begin
                    state_next = SEQ_EMIT;
                    row_next   = '0;
                    col_next   = '0;
                    imag_next  = 1'b0;
                end
            end
            SEQ_EMIT: begin
                if (adv) begin
                    if (!imag_reg && (row_reg != col_reg)) begin
                        imag_next = 1'b1;
                    end else begin
                        imag_next = 1'b0;
                        if (col_reg == n_last) begin
                            if (row_reg == n_last) begin
                                state_next = SEQ_IDLE;
                            end else begin
                                row_next = row_reg + 1'b1;
                                col_next = row_reg + 1'b1;
                            end
                        end else begin
                            col_next = col_reg + 1'b1;
                        end
                    end
                end
            end
            default: state_next = SEQ_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= SEQ_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            imag_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            imag_reg  <= imag_next;
        end
    end

endmodule

// ===== rtl/cpcp_mac.sv =====
// Multiply pipeline: four 16x16 products, then add or subtract into the output register.
// Depends on cpcp_pkg; takes sample words from the registered read ports of cpcp_sample_ram.
module cpcp_mac import cpcp_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              issue,
    input  prod_tag_t         tag_in,
    input  logic [WORD_W-1:0] word_a,
    input  logic [WORD_W-1:0] word_b,
    input  logic              m_ready,
    output logic              adv,
    output logic              out_valid,
    output prod_tag_t         out_tag,
    output logic [PROD_W-1:0] out_value
);

    logic                     v1_reg, v2_reg, out_valid_reg;
    prod_tag_t                tag1_reg, tag2_reg, out_tag_reg;
    logic signed [PROD_W-1:0] rr_reg, ii_reg, ri_reg, ir_reg;
    logic [PROD_W-1:0]        out_value_reg;
    logic signed [SAMPLE_W-1:0] re_a, im_a, re_b, im_b;
    logic signed [PROD_W-1:0]   result;

    // Advance the whole pipeline unless the output holds an untaken result
    assign adv = !out_valid_reg || m_ready;

    assign re_a = $signed(word_a[SAMPLE_W-1:0]);
    assign im_a = $signed(word_a[WORD_W-1:SAMPLE_W]);
    assign re_b = $signed(word_b[SAMPLE_W-1:0]);
    assign im_b = $signed(word_b[WORD_W-1:SAMPLE_W]);

    // Sums wrap modulo 2^32
    assign result = tag2_reg.imag ? (ri_reg - ir_reg) : (rr_reg + ii_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            v1_reg        <= issue;
            v2_reg        <= v1_reg;
            out_valid_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            tag1_reg      <= tag_in;
            tag2_reg      <= tag1_reg;
            rr_reg        <= re_a * re_b;
            ii_reg        <= im_a * im_b;
            ri_reg        <= re_a * im_b;
            ir_reg        <= im_a * re_b;
            out_tag_reg   <= tag2_reg;
            out_value_reg <= result;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_tag   = out_tag_reg;
    assign out_value = out_value_reg;

endmodule

// ===== rtl/channel_pair_cross_power.sv =====
// Cross power of every channel pair for one frequency bin per run of samples.
// After a run's last sample is accepted, its first result passes the sequencer state, the
// sample read registers, the product registers and the output register. A run of n samples
// yields n*n products, one product request per cycle while the output does not stall.
// Reset (aresetn low, synchronous) clears the run count, bin, pipeline and output valid,
// and sets num_channels to 8; the sample memory is not cleared.
module channel_pair_cross_power import cpcp_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    // Configuration write: num_channels
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [NUM_W-1:0]    cfg_data,
    // Sample input
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [S_DATA_W-1:0] s_tdata,   // [15:0] sample_re, [31:16] sample_im, [43:32] bin_in
    // Product output
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [M_DATA_W-1:0] m_tdata,   // [2:0] row_channel, [5:3] col_channel,
                                           // [17:6] bin_out, [49:18] product_value
    output logic                m_tuser,   // [0] is_imaginary
    output logic                m_tlast    // last_of_run
);

    logic [NUM_W-1:0] num_channels_reg;
    logic [CH_W-1:0]  load_cnt_reg;
    logic [BIN_W-1:0] bin_reg;
    logic [CH_W-1:0]  n_last;
    logic             s_accept;
    logic             cfg_accept;
    logic             start;
    logic             busy;
    logic             issue;
    logic             adv;
    prod_tag_t        req_tag;
    prod_tag_t        out_tag;
    logic [WORD_W-1:0] word_a, word_b;
    logic [PROD_W-1:0] out_value;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;

    // Take new samples whenever no run is being expanded into products;
    // the output register lets a fresh run load while the last products drain.
    assign s_tready = !busy;
    assign s_accept = s_tvalid && s_tready;

    // Clamp the channel count: zero acts as one, above the maximum acts as the maximum
    always_comb begin
        if (num_channels_reg == '0) begin
            n_last = '0;
        end else if (num_channels_reg > NUM_W'(MAX_CHANNELS)) begin
            n_last = CH_W'(MAX_CHANNELS - 1);
        end else begin
            n_last = CH_W'(num_channels_reg - 1'b1);
        end
    end

    // The final sample of a run kicks off the pair sequencer
    assign start = s_accept && (load_cnt_reg == n_last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_channels_reg <= NUM_W'(MAX_CHANNELS);
            load_cnt_reg     <= '0;
            bin_reg          <= '0;
        end else if (cfg_accept) begin
            // Drop any partly loaded run
            num_channels_reg <= cfg_data;
            load_cnt_reg     <= '0;
        end else if (s_accept) begin
            if (load_cnt_reg == '0) begin
                bin_reg <= s_tdata[WORD_W +: BIN_W];
            end
            if (start) begin
                load_cnt_reg <= '0;
            end else begin
                load_cnt_reg <= load_cnt_reg + 1'b1;
            end
        end
    end

    cpcp_sample_ram u_ram (
        .aclk      (aclk),
        .wr_en     (s_accept),
        .wr_addr   (load_cnt_reg),
        .wr_data   (s_tdata[WORD_W-1:0]),
        .rd_en     (issue),
        .rd_addr_a (req_tag.imag ? req_tag.col : req_tag.row),
        .rd_addr_b (req_tag.imag ? req_tag.row : req_tag.col),
        .rd_data_a (word_a),
        .rd_data_b (word_b)
    );

    cpcp_pair_seq u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (start),
        .n_last  (n_last),
        .bin     (bin_reg),
        .adv     (adv),
        .busy    (busy),
        .issue   (issue),
        .tag     (req_tag)
    );

    cpcp_mac u_mac (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .issue     (issue),
        .tag_in    (req_tag),
        .word_a    (word_a),
        .word_b    (word_b),
        .m_ready   (m_tready),
        .adv       (adv),
        .out_valid (m_tvalid),
        .out_tag   (out_tag),
        .out_value (out_value)
    );

    assign m_tdata = {{(M_DATA_W - 2*CH_W - BIN_W - PROD_W){1'b0}},
                      out_value, out_tag.bin, out_tag.col, out_tag.row};
    assign m_tuser = out_tag.imag;
    assign m_tlast = out_tag.last;

    // A completed run always puts the sequencer to work on the next cycle
    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        start && !cfg_accept |=> busy)
        else $error("run completed without starting the pair sequence");

    // The run's final product is a real diagonal term
    a_last_real: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> !m_tuser && (out_tag.row == out_tag.col))
        else $error("last product of a run is not a real diagonal term");

    // Imaginary products sit below the diagonal
    a_imag_lower: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> (out_tag.row > out_tag.col))
        else $error("imaginary product placed on or above the diagonal");

    // The load position never passes the last active channel
    a_load_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        load_cnt_reg <= n_last)
        else $error("load position beyond the active channel count");

endmodule
